// ===== rtl/lkf_pkg.sv =====
package lkf_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int PIXEL_BITS_DEF = 8;
   localparam int FRAC_BITS_DEF  = 8;

   localparam int MAX_HEIGHT     = 1024;
   localparam int ROW_W          = 10;
   localparam int HEIGHT_W       = 11;
   localparam int DIM_MIN        = 3;
   localparam int DIM_RESET      = 200;
   localparam int NUM_PRODUCTS   = 5;
   localparam int FIELD_W        = 8;
   localparam int FLOW_W         = 16;
   localparam int QUOT_W         = 17;

   localparam int CSR_DATA_W     = 11;
   localparam int CSR_INDEX_W    = 2;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type REG_IMAGE_WIDTH  = 2'd0;
   localparam csr_index_type REG_IMAGE_HEIGHT = 2'd1;

   localparam logic [QUOT_W-1:0] QUOT_POS_LIMIT = 17'd32767;
   localparam logic [QUOT_W-1:0] QUOT_NEG_LIMIT = 17'd32768;
   localparam logic signed [FLOW_W-1:0] FLOW_MAX = 16'sh7fff;
   localparam logic signed [FLOW_W-1:0] FLOW_MIN = 16'sh8000;

   typedef struct packed {
      logic [FIELD_W-1:0] first_pixel;
      logic [FIELD_W-1:0] second_pixel;
   } req_type;

   typedef struct packed {
      logic signed [FLOW_W-1:0] flow_u;
      logic signed [FLOW_W-1:0] flow_v;
      logic                     run_last;
   } rsp_type;

   typedef struct packed {
      logic done;
      logic sat;
   } div_status_type;

endpackage

// ===== rtl/lkf_ram.sv =====
module lkf_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lkf_div.sv =====
module lkf_div #(
   parameter int NUM_W  = 51,
   parameter int DEN_W  = 50,
   parameter int FRAC_W = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUM_W-1:0]       num,
   input  logic [DEN_W-1:0]       den,
   output logic [lkf_pkg::QUOT_W-1:0] quot,
   output lkf_pkg::div_status_type status
);

   import lkf_pkg::*;

   localparam int REM_W  = NUM_W + FRAC_W;
   localparam int DSH_W  = DEN_W + QUOT_W - 1;
   localparam int SAT_W  = DEN_W + QUOT_W;
   localparam int CMP_W  = ((REM_W > SAT_W) ? REM_W : SAT_W) + 1;
   localparam int CNT_W  = $clog2(QUOT_W + 1);

   logic [REM_W-1:0]  rem_ff;
   logic [DSH_W-1:0]  dsh_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic              sat_ff;

   logic [CMP_W-1:0]  rem_x;
   logic [CMP_W-1:0]  dsh_x;
   logic [CMP_W-1:0]  diff_x;
   logic              ge;

   always_comb begin
      rem_x  = CMP_W'(rem_ff);
      dsh_x  = CMP_W'(dsh_ff);
      diff_x = rem_x - dsh_x;
      ge     = (rem_x >= dsh_x);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (cnt_ff == CNT_W'(1))) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {num, {FRAC_W{1'b0}}};
         dsh_ff  <= {den, {(QUOT_W-1){1'b0}}};
         quot_ff <= '0;
         cnt_ff  <= CNT_W'(QUOT_W);
         sat_ff  <= (CMP_W'({num, {FRAC_W{1'b0}}}) >= CMP_W'({den, {QUOT_W{1'b0}}}));
      end else if (run_ff) begin
         if (ge) begin
            rem_ff <= REM_W'(diff_x);
         end
         quot_ff <= {quot_ff[QUOT_W-2:0], ge};
         dsh_ff  <= dsh_ff >> 1;
         cnt_ff  <= cnt_ff - CNT_W'(1);
      end
   end

   assign quot        = quot_ff;
   assign status.done = done_ff;
   assign status.sat  = sat_ff;

endmodule

// ===== rtl/lucas_kanade_flow_3x3.sv =====
// Channel   Ports                                  Moves
// req       req_valid, req_ready, req_payload      one pixel pair per item, raster order
// rsp       rsp_valid, rsp_ready, rsp_payload      flow_u, flow_v, run_last per item
// csr       csr_write_en, csr_index, csr_wdata     image_width, image_height writes
//
// No-result items end after gradients, border results skip the solve, interior items run
// the 17-step restoring quotient loop; column 1 adds a column pass, the last column an item.
// One read and one write per cycle on the pixel row RAM and the product row RAM.
// Reset sets width and height to 200 and the position to row 0, column 0; no clearing pass.
// A result waiting in the output register stalls only the emit step; the next item
// is taken once the last result of the current one is loaded.
module lucas_kanade_flow_3x3 #(
   parameter int MAX_WIDTH  = lkf_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = lkf_pkg::PIXEL_BITS_DEF,
   parameter int FRAC_BITS  = lkf_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lkf_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lkf_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_write_en,
   input  lkf_pkg::csr_index_type            csr_index,
   input  logic [lkf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import lkf_pkg::*;

   localparam int CNT_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WCW         = $clog2(MAX_WIDTH + 1);
   localparam int WCMP        = (WCW > CSR_DATA_W) ? WCW : CSR_DATA_W;
   localparam int WIDTH_RESET = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
   localparam int GW          = PIXEL_BITS + 3;
   localparam int PW          = 2 * GW - 1;
   localparam int CW          = PW + 2;
   localparam int SW          = PW + 4;
   localparam int TW          = 2 * SW;
   localparam int NUM_W       = TW + 1;
   localparam int PIX_W       = 2 * PIXEL_BITS;
   localparam int PROW_W      = 2 * NUM_PRODUCTS * PW;
   localparam int PIX_DEPTH   = 2 << CNT_W;
   localparam int PROD_DEPTH  = 1 << CNT_W;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_GRAD  = 11'b000_0000_0010,
      S_MUL   = 11'b000_0000_0100,
      S_COL   = 11'b000_0000_1000,
      S_CWAIT = 11'b000_0001_0000,
      S_SUM   = 11'b000_0010_0000,
      S_PROD  = 11'b000_0100_0000,
      S_DIFF  = 11'b000_1000_0000,
      S_DIV   = 11'b001_0000_0000,
      S_EMIT0 = 11'b010_0000_0000,
      S_EMIT1 = 11'b100_0000_0000
   } state_type;

   function automatic logic signed [GW-1:0] pix_ext(input logic [PIXEL_BITS-1:0] x);
      pix_ext = signed'(GW'(x));
   endfunction

   function automatic logic signed [FLOW_W-1:0] flow_sat(input logic neg, input logic sat,
                                                         input logic [QUOT_W-1:0] q);
      logic [QUOT_W-1:0] nq;
      nq = QUOT_W'(0) - q;
      if (!neg) begin
         flow_sat = (sat || (q > QUOT_POS_LIMIT)) ? FLOW_MAX : signed'(q[FLOW_W-1:0]);
      end else begin
         flow_sat = (sat || (q > QUOT_NEG_LIMIT)) ? FLOW_MIN : signed'(nq[FLOW_W-1:0]);
      end
   endfunction

   state_type state_ff, state_in;
   logic [WCW-1:0]      width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [CNT_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                go_ff;

   logic [CNT_W-1:0]    itm_col_ff;
   logic [ROW_W-1:0]    itm_row_ff;
   logic [PIX_W-1:0]    pix_e_ff;
   logic [PIX_W-1:0]    pix_d_ff;
   logic [PIX_W-1:0]    pix_a_ff;
   logic                phase_ff;
   logic signed [GW-1:0] fx_ff, fy_ff, ft_ff;
   logic signed [PW-1:0] p_ff [NUM_PRODUCTS];
   logic signed [CW-1:0] win_ff [3][NUM_PRODUCTS];
   logic signed [SW-1:0] s_ff [NUM_PRODUCTS];
   logic signed [TW-1:0] t_ff [6];
   logic [TW-1:0]       det_ff;
   logic                det_pos_ff;
   logic [NUM_W-1:0]    mag_u_ff, mag_v_ff;
   logic                neg_u_ff, neg_v_ff;
   logic signed [FLOW_W-1:0] res_u_ff, res_v_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                accept;
   logic                out_free;
   logic                last_col;
   logic                solve_go;
   logic [WCW-1:0]      col_inc;
   logic [HEIGHT_W-1:0] row_inc;
   logic [WCMP-1:0]     wv;

   logic                pix_wr_en, pix_rd_en;
   logic [CNT_W:0]      pix_wr_addr, pix_rd_addr;
   logic [PIX_W-1:0]    pix_wr_data, pix_rd_data;
   logic                prod_wr_en, prod_rd_en;
   logic [CNT_W-1:0]    prod_wr_addr, prod_rd_addr;
   logic [PROW_W-1:0]   prod_wr_data, prod_rd_data;

   logic signed [GW-1:0] a1, a2, b1, b2, d1, d2, e1, e2;
   logic signed [GW-1:0] fx_c, fy_c, ft_c;
   logic signed [PW-1:0] p_c [NUM_PRODUCTS];
   logic signed [PW-1:0] pp [NUM_PRODUCTS];
   logic signed [PW-1:0] old0 [NUM_PRODUCTS];
   logic signed [PW-1:0] old1 [NUM_PRODUCTS];
   logic signed [PW-1:0] refl [NUM_PRODUCTS];
   logic signed [CW-1:0] vs [NUM_PRODUCTS];
   logic signed [TW:0]   det_c, du_c, dv_c;

   logic [QUOT_W-1:0]   quot_u, quot_v;
   div_status_type      stat_u, stat_v;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_col  = (WCW'(itm_col_ff) == (width_ff - WCW'(1)));
   assign solve_go  = (itm_row_ff >= ROW_W'(2)) && (itm_col_ff >= CNT_W'(2));
   assign col_inc   = WCW'(col_ff) + WCW'(1);
   assign row_inc   = HEIGHT_W'(row_ff) + HEIGHT_W'(1);
   assign wv        = WCMP'(csr_wdata);

   // pixel rows: bank is the row parity
   assign pix_wr_en   = accept;
   assign pix_wr_addr = {row_ff[0], col_ff};
   assign pix_wr_data = {PIXEL_BITS'(req_payload.second_pixel),
                         PIXEL_BITS'(req_payload.first_pixel)};
   assign pix_rd_en   = accept;
   assign pix_rd_addr = {~row_ff[0], col_ff};

   lkf_ram #(.WIDTH(PIX_W), .DEPTH(PIX_DEPTH)) u_pix_ram (
      .clock   (clock),
      .wr_en   (pix_wr_en),
      .wr_addr (pix_wr_addr),
      .wr_data (pix_wr_data),
      .rd_en   (pix_rd_en),
      .rd_addr (pix_rd_addr),
      .rd_data (pix_rd_data)
   );

   // product rows: entry holds rows r-1 (upper) and r-2 (lower) of one column
   assign prod_wr_en   = (state_ff == S_COL);
   assign prod_wr_addr = phase_ff ? '0 : itm_col_ff;
   assign prod_rd_en   = (state_ff == S_GRAD) || ((state_ff == S_COL) && phase_ff);
   assign prod_rd_addr = ((state_ff == S_GRAD) && (itm_col_ff == CNT_W'(1))) ? '0
                                                                              : itm_col_ff;

   lkf_ram #(.WIDTH(PROW_W), .DEPTH(PROD_DEPTH)) u_prod_ram (
      .clock   (clock),
      .wr_en   (prod_wr_en),
      .wr_addr (prod_wr_addr),
      .wr_data (prod_wr_data),
      .rd_en   (prod_rd_en),
      .rd_addr (prod_rd_addr),
      .rd_data (prod_rd_data)
   );

   always_comb begin
      a1 = pix_ext(pix_a_ff[PIXEL_BITS-1:0]);
      a2 = pix_ext(pix_a_ff[PIX_W-1:PIXEL_BITS]);
      b1 = pix_ext(pix_rd_data[PIXEL_BITS-1:0]);
      b2 = pix_ext(pix_rd_data[PIX_W-1:PIXEL_BITS]);
      d1 = pix_ext(pix_d_ff[PIXEL_BITS-1:0]);
      d2 = pix_ext(pix_d_ff[PIX_W-1:PIXEL_BITS]);
      e1 = pix_ext(pix_e_ff[PIXEL_BITS-1:0]);
      e2 = pix_ext(pix_e_ff[PIX_W-1:PIXEL_BITS]);
      fx_c = (b1 - a1 + e1 - d1) + (b2 - a2 + e2 - d2);
      fy_c = (d1 - a1 + e1 - b1) + (d2 - a2 + e2 - b2);
      ft_c = (a2 + b2 + d2 + e2) - (a1 + b1 + d1 + e1);
   end

   always_comb begin
      p_c[0] = fx_ff * fx_ff;
      p_c[1] = fy_ff * fy_ff;
      p_c[2] = fx_ff * fy_ff;
      p_c[3] = fx_ff * ft_ff;
      p_c[4] = fy_ff * ft_ff;
   end

   always_comb begin
      for (int k = 0; k < NUM_PRODUCTS; k++) begin
         pp[k]   = (phase_ff && (k == 2 || k == 3)) ? -p_ff[k] : p_ff[k];
         old0[k] = signed'(prod_rd_data[(NUM_PRODUCTS + k) * PW +: PW]);
         old1[k] = signed'(prod_rd_data[k * PW +: PW]);
         refl[k] = (k == 2 || k == 4) ? -pp[k] : pp[k];
         vs[k]   = CW'(old0[k]) + CW'(old1[k]) + CW'(pp[k]);
         prod_wr_data[(NUM_PRODUCTS + k) * PW +: PW] = pp[k];
         prod_wr_data[k * PW +: PW] = (itm_row_ff == ROW_W'(1)) ? refl[k] : old0[k];
      end
   end

   always_comb begin
      det_c = (TW + 1)'(t_ff[0]) - (TW + 1)'(t_ff[1]);
      du_c  = (TW + 1)'(t_ff[2]) - (TW + 1)'(t_ff[3]);
      dv_c  = (TW + 1)'(t_ff[4]) - (TW + 1)'(t_ff[5]);
   end

   always_comb begin
      state_in  = state_ff;
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH: begin
               if (wv < WCMP'(DIM_MIN)) begin
                  width_in = WCW'(DIM_MIN);
               end else if (wv > WCMP'(MAX_WIDTH)) begin
                  width_in = WCW'(MAX_WIDTH);
               end else begin
                  width_in = WCW'(wv);
               end
               col_in = '0;
               row_in = '0;
            end
            REG_IMAGE_HEIGHT: begin
               if (csr_wdata < HEIGHT_W'(DIM_MIN)) begin
                  height_in = HEIGHT_W'(DIM_MIN);
               end else if (csr_wdata > HEIGHT_W'(MAX_HEIGHT)) begin
                  height_in = HEIGHT_W'(MAX_HEIGHT);
               end else begin
                  height_in = csr_wdata;
               end
               col_in = '0;
               row_in = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (col_inc >= width_ff) begin
            col_in = '0;
            row_in = (row_inc >= height_ff) ? '0 : ROW_W'(row_inc);
         end else begin
            col_in = CNT_W'(col_inc);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_GRAD;
         end
         S_GRAD: begin
            if ((itm_row_ff == '0) || (itm_col_ff == '0)) state_in = S_IDLE;
            else state_in = S_MUL;
         end
         S_MUL:   state_in = S_COL;
         S_COL: begin
            if (phase_ff) state_in = S_CWAIT;
            else if (solve_go) state_in = S_SUM;
            else state_in = S_EMIT0;
         end
         S_CWAIT: state_in = S_COL;
         S_SUM:   state_in = S_PROD;
         S_PROD:  state_in = S_DIFF;
         S_DIFF:  state_in = S_DIV;
         S_DIV: begin
            if (stat_u.done) state_in = S_EMIT0;
         end
         S_EMIT0: begin
            if (out_free) state_in = last_col ? S_EMIT1 : S_IDLE;
         end
         S_EMIT1: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= WCW'(WIDTH_RESET);
         height_ff <= HEIGHT_W'(DIM_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
         go_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         go_ff     <= (state_ff == S_DIFF);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < NUM_PRODUCTS; k++) begin
               win_ff[j][k] <= '0;
            end
         end
      end else if ((state_ff == S_COL) && (itm_row_ff != ROW_W'(1))) begin
         for (int k = 0; k < NUM_PRODUCTS; k++) begin
            win_ff[0][k] <= win_ff[1][k];
            win_ff[1][k] <= win_ff[2][k];
            win_ff[2][k] <= vs[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pix_e_ff   <= pix_wr_data;
               itm_col_ff <= col_ff;
               itm_row_ff <= row_ff;
            end
         end
         S_GRAD: begin
            fx_ff    <= fx_c;
            fy_ff    <= fy_c;
            ft_ff    <= ft_c;
            pix_a_ff <= pix_rd_data;
            pix_d_ff <= pix_e_ff;
            phase_ff <= (itm_col_ff == CNT_W'(1));
         end
         S_MUL: begin
            for (int k = 0; k < NUM_PRODUCTS; k++) p_ff[k] <= p_c[k];
         end
         S_COL: begin
            phase_ff <= 1'b0;
            res_u_ff <= '0;
            res_v_ff <= '0;
         end
         S_SUM: begin
            for (int k = 0; k < NUM_PRODUCTS; k++) begin
               s_ff[k] <= SW'(win_ff[0][k]) + SW'(win_ff[1][k]) + SW'(win_ff[2][k]);
            end
         end
         S_PROD: begin
            t_ff[0] <= s_ff[0] * s_ff[1];
            t_ff[1] <= s_ff[2] * s_ff[2];
            t_ff[2] <= s_ff[2] * s_ff[4];
            t_ff[3] <= s_ff[1] * s_ff[3];
            t_ff[4] <= s_ff[3] * s_ff[2];
            t_ff[5] <= s_ff[0] * s_ff[4];
         end
         S_DIFF: begin
            det_ff     <= det_c[TW-1:0];
            det_pos_ff <= !det_c[TW] && (det_c != '0);
            neg_u_ff   <= du_c[TW];
            neg_v_ff   <= dv_c[TW];
            mag_u_ff   <= du_c[TW] ? NUM_W'(-du_c) : NUM_W'(du_c);
            mag_v_ff   <= dv_c[TW] ? NUM_W'(-dv_c) : NUM_W'(dv_c);
         end
         S_DIV: begin
            if (stat_u.done) begin
               res_u_ff <= det_pos_ff ? flow_sat(neg_u_ff, stat_u.sat, quot_u) : '0;
               res_v_ff <= det_pos_ff ? flow_sat(neg_v_ff, stat_v.sat, quot_v) : '0;
            end
         end
         default: begin
         end
      endcase
   end

   lkf_div #(.NUM_W(NUM_W), .DEN_W(TW), .FRAC_W(FRAC_BITS)) u_div_u (
      .clock  (clock),
      .reset  (reset),
      .start  (go_ff),
      .num    (mag_u_ff),
      .den    (det_ff),
      .quot   (quot_u),
      .status (stat_u)
   );

   lkf_div #(.NUM_W(NUM_W), .DEN_W(TW), .FRAC_W(FRAC_BITS)) u_div_v (
      .clock  (clock),
      .reset  (reset),
      .start  (go_ff),
      .num    (mag_v_ff),
      .den    (det_ff),
      .quot   (quot_v),
      .status (stat_v)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_EMIT0) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if ((state_ff == S_EMIT1) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_EMIT0) && out_free) begin
         rsp_data_ff.flow_u   <= res_u_ff;
         rsp_data_ff.flow_v   <= res_v_ff;
         rsp_data_ff.run_last <= !last_col;
      end else if ((state_ff == S_EMIT1) && out_free) begin
         rsp_data_ff.flow_u   <= '0;
         rsp_data_ff.flow_v   <= '0;
         rsp_data_ff.run_last <= 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      stat_u.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide step");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      stat_u.done == stat_v.done)
      else $error("u and v dividers out of step");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      WCW'(col_ff) < width_ff)
      else $error("column position beyond image width");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      HEIGHT_W'(row_ff) < height_ff)
      else $error("row position beyond image height");

   a_emit_load: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EMIT0) && out_free) |=> rsp_valid_ff)
      else $error("result not loaded into output register");
`endif

endmodule

// ===== tb/sv/lucas_kanade_flow_3x3_test.sv =====
`timescale 1ns / 1ps

module lucas_kanade_flow_3x3_test;
   import lkf_pkg::*;

   localparam int MAX_W = 1024;
   localparam int IDLE_CYCLES = 60;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_write_en = 1'b0;
   csr_index_type csr_index = REG_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lucas_kanade_flow_3x3 dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   rsp_type flow_queue[$];
   int errors = 0;
   bit steady = 1'b0;
   int hold_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   int unsigned img_w = DIM_RESET, img_h = DIM_RESET;
   int unsigned col_pos = 0, row_pos = 0;
   logic [31:0] pix_store[2][MAX_W];
   longint prod_store[2][MAX_W][5];
   longint win_cols[3][5];

   task automatic accum_column(int unsigned r, int unsigned c, longint p[5]);
      longint vs[5];
      if (r == 1) begin
         for (int k = 0; k < 5; k++) begin
            prod_store[1][c][k] = p[k];
            prod_store[0][c][k] = (k == 2 || k == 4) ? -p[k] : p[k];
         end
         return;
      end
      for (int k = 0; k < 5; k++) begin
         vs[k] = prod_store[r & 1][c][k] + prod_store[(r - 1) & 1][c][k] + p[k];
         prod_store[r & 1][c][k] = p[k];
      end
      win_cols[0] = win_cols[1];
      win_cols[1] = win_cols[2];
      win_cols[2] = vs;
   endtask

   function automatic logic [15:0] q88(bit neg, longint unsigned mag, longint unsigned det);
      longint unsigned ip, rem, q;
      ip = mag / det;
      rem = mag % det;
      if (ip >= 65536) return neg ? 16'h8000 : 16'h7fff;
      q = ip << FRAC_BITS_DEF;
      for (int i = FRAC_BITS_DEF - 1; i >= 0; i--) begin
         rem = rem << 1;
         if (rem >= det) begin
            rem -= det;
            q |= longint'(1) << i;
         end
      end
      if (!neg) return (q > 32767) ? 16'h7fff : q[15:0];
      if (q > 32768) return 16'h8000;
      return 16'(-q);
   endfunction

   function automatic rsp_type solve_flow();
      longint s[5];
      longint det, a, b;
      rsp_type o;
      o = '0;
      for (int k = 0; k < 5; k++) s[k] = win_cols[0][k] + win_cols[1][k] + win_cols[2][k];
      det = s[0] * s[1] - s[2] * s[2];
      if (det <= 0) return o;
      a = s[2] * s[4];
      b = s[1] * s[3];
      o.flow_u = (a >= b) ? q88(0, a - b, det) : q88(1, b - a, det);
      a = s[3] * s[2];
      b = s[0] * s[4];
      o.flow_v = (a >= b) ? q88(0, a - b, det) : q88(1, b - a, det);
      return o;
   endfunction

   task automatic predict_flow(req_type px);
      int unsigned r, c, cur, prv;
      longint a1, a2, b1, b2, d1, d2, e1, e2, fx, fy, ft;
      longint p[5], p0[5];
      rsp_type o;
      r = row_pos;
      c = (col_pos >= img_w) ? img_w - 1 : col_pos;
      cur = r & 1;
      prv = cur ^ 1;
      if (r >= 1 && c >= 1) begin
         a1 = longint'(pix_store[prv][c - 1][15:0]);
         a2 = longint'(pix_store[prv][c - 1][31:16]);
         b1 = longint'(pix_store[prv][c][15:0]);
         b2 = longint'(pix_store[prv][c][31:16]);
         d1 = longint'(pix_store[cur][c - 1][15:0]);
         d2 = longint'(pix_store[cur][c - 1][31:16]);
         e1 = longint'(px.first_pixel);
         e2 = longint'(px.second_pixel);
         fx = (b1 - a1 + e1 - d1) + (b2 - a2 + e2 - d2);
         fy = (d1 - a1 + e1 - b1) + (d2 - a2 + e2 - b2);
         ft = (a2 + b2 + d2 + e2) - (a1 + b1 + d1 + e1);
         p[0] = fx * fx; p[1] = fy * fy; p[2] = fx * fy; p[3] = fx * ft; p[4] = fy * ft;
         if (c == 1) begin
            p0 = p;
            p0[2] = -p0[2];
            p0[3] = -p0[3];
            accum_column(r, 0, p0);
         end
         accum_column(r, c, p);
      end
      pix_store[cur][c] = {8'd0, px.second_pixel, 8'd0, px.first_pixel};
      if (r >= 1 && c >= 1) begin
         o = (r >= 2 && c >= 2) ? solve_flow() : rsp_type'('0);
         o.run_last = (c != img_w - 1);
         flow_queue = {flow_queue, o};
         if (c == img_w - 1) begin
            o = '0;
            o.run_last = 1'b1;
            flow_queue = {flow_queue, o};
         end
      end
      c++;
      if (c >= img_w) begin
         c = 0;
         r++;
         if (r >= img_h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   function automatic int pick_gap();
      int x;
      if (steady) return 0;
      x = $urandom_range(0, 99);
      if (x < 55) return 0;
      if (x < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_pixel(req_type px);
      int gap;
      req_valid <= 1'b1;
      req_payload <= px;
      do @(posedge clock); while (!req_ready);
      predict_flow(px);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (flow_queue.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
         if (idx == REG_IMAGE_WIDTH)
            img_w = (value < DIM_MIN) ? DIM_MIN : (value > MAX_W) ? MAX_W : value;
         else
            img_h = (value < DIM_MIN) ? DIM_MIN : (value > MAX_HEIGHT) ? MAX_HEIGHT : value;
         col_pos = 0;
         row_pos = 0;
      end
   endtask

   function automatic req_type make_pixel(int mode, int unsigned r, int unsigned c);
      req_type px;
      int base;
      case (mode)
         0: begin
            px.first_pixel = 8'($urandom);
            px.second_pixel = 8'($urandom);
         end
         1: begin
            px.first_pixel = 8'(3 + $urandom_range(0, 1));
            px.second_pixel = 8'(250 - $urandom_range(0, 1));
         end
         default: begin
            base = (c * 23 + r * 11 + (c * r) % 7) & 255;
            px.first_pixel = 8'(base);
            px.second_pixel = 8'((base + 20 + $urandom_range(0, 3)) & 255);
         end
      endcase
      return px;
   endfunction

   task automatic run_frames(int count, int items);
      for (int i = 0; i < count; i++) begin
         for (int k = 0; k < items; k++)
            send_pixel(make_pixel($urandom_range(0, 2), row_pos, col_pos));
      end
   endtask

   task automatic test_directed();
      req_type px;
      write_reg(REG_IMAGE_WIDTH, 11'd3);
      write_reg(REG_IMAGE_HEIGHT, 11'd3);
      for (int k = 0; k < 9; k++) begin
         px.first_pixel = (k % 2) ? 8'hff : 8'h00;
         px.second_pixel = (k % 3) ? 8'h00 : 8'hff;
         send_pixel(px);
      end
      write_reg(REG_IMAGE_WIDTH, 11'd4);
      for (int k = 0; k < 16; k++) begin
         px.first_pixel = (k[0] ^ k[2]) ? 8'hff : 8'h00;
         px.second_pixel = 8'h80 + 8'(k);
         send_pixel(px);
      end
   endtask

   task automatic test_singular_and_saturation();
      write_reg(REG_IMAGE_WIDTH, 11'd5);
      write_reg(REG_IMAGE_HEIGHT, 11'd5);
      for (int k = 0; k < 25; k++) send_pixel('{first_pixel: 8'd77, second_pixel: 8'd77});
      for (int k = 0; k < 50; k++) send_pixel(make_pixel(1, row_pos, col_pos));
   endtask

   task automatic test_registers();
      write_reg(REG_IMAGE_WIDTH, 11'd0);
      write_reg(REG_IMAGE_HEIGHT, 11'd2);
      run_frames(1, 14);
      write_reg(csr_index_type'(2), 11'd9);
      write_reg(csr_index_type'(3), 11'd9);
      run_frames(1, 10);
      write_reg(REG_IMAGE_HEIGHT, 11'd2047);
      write_reg(REG_IMAGE_WIDTH, 11'd2047);
      run_frames(1, MAX_W + 40);
      write_reg(REG_IMAGE_WIDTH, 11'd1024);
      write_reg(REG_IMAGE_HEIGHT, 11'd1024);
      run_frames(1, 30);
   endtask

   task automatic test_random_frames(int target);
      int sent, w, h, frames, items;
      sent = 0;
      while (sent < target) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(3, 10);
         h = $urandom_range(3, 7);
         write_reg(REG_IMAGE_WIDTH, 11'(w));
         write_reg(REG_IMAGE_HEIGHT, 11'(h));
         steady = ($urandom_range(0, 4) == 0);
         frames = $urandom_range(1, 2);
         items = w * h + (($urandom_range(0, 3) == 0) ? w + 1 : 0);
         run_frames(frames, items);
         sent += frames * items;
         steady = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      write_reg(REG_IMAGE_WIDTH, 11'd6);
      write_reg(REG_IMAGE_HEIGHT, 11'd6);
      steady = 1'b1;
      hold_left = 3000;
      run_frames(1, 60);
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < 20)
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                       : $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (flow_queue.size() == 0) begin
            $error("flow item with none expected");
            errors++;
         end else begin
            want = flow_queue.pop_front();
            if (rsp_payload.flow_u !== want.flow_u) begin
               $error("flow_u expected %0d actual %0d", want.flow_u, rsp_payload.flow_u);
               errors++;
            end
            if (rsp_payload.flow_v !== want.flow_v) begin
               $error("flow_v expected %0d actual %0d", want.flow_v, rsp_payload.flow_v);
               errors++;
            end
            if (rsp_payload.run_last !== want.run_last) begin
               $error("run_last expected %0d actual %0d", want.run_last,
                      rsp_payload.run_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_singular_and_saturation();
      test_registers();
      test_backpressure();
      test_random_frames(470);
      wait_idle();
      if (errors == 0 && flow_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lkf_pkg.sv
rtl/lkf_ram.sv
rtl/lkf_div.sv
rtl/lucas_kanade_flow_3x3.sv
tb/sv/lucas_kanade_flow_3x3_test.sv
